>>> rtl/core/dual_interrupt_controller_defines.svh
// Assertion macros for the dual interrupt controller checker.
// Depends on nothing; included by the checker file.
`ifndef DUAL_INTERRUPT_CONTROLLER_DEFINES_SVH
`define DUAL_INTERRUPT_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define DIC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dic check failed");

// next-cycle implication
`define DIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dic check failed");

`endif

>>> rtl/core/dic_pkg.sv
// Shared types, codes and helpers for the dual interrupt controller.
// No dependencies.
package dic_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RAISE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STEP_IDLE    = 2'd0,
        STEP_BASE    = 2'd1,
        STEP_CASCADE = 2'd2,
        STEP_FOURTH  = 2'd3
    } t_step;

    localparam logic       RES_READ   = 1'b0;
    localparam logic       RES_VECTOR = 1'b1;
    localparam int unsigned INIT_BIT     = 4;
    localparam int unsigned FOURTH_BIT   = 0;
    localparam int unsigned CASCADE_LINE = 2;
    localparam logic [7:0] MASK_ALL   = 8'hff;

    typedef struct packed {
        logic [1:0] kind;
        logic       chip_select;
        logic       command_port;
        logic [7:0] data;
        logic [3:0] irq_line;
    } t_in_beat;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] value;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic       vld;
        logic       rkind;
        logic [7:0] value;
        logic [7:0] rem;
        logic [4:0] base;
    } t_load;

    typedef struct packed {
        logic burst_active;
        logic slot_held;
    } t_seq_stat;

    function automatic logic [2:0] low_index(input logic [7:0] bits);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (bits[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/core/dual_interrupt_controller.sv
// A read or delivered vector is registered and appears the cycle after acceptance.
// One beat per cycle unless stalled; a mask write replaying k pending lines emits k
// vectors, one per unstalled cycle, holding off input until the last is registered.
// Reset (synchronous, active low): masks all ones, pending and bases zero,
// both chips idle, no result held.
module dual_interrupt_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dic_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dic_pkg::t_out_beat o_out_beat
);

    logic [4:0]     r_base [2], n_base [2];
    logic [7:0]     r_mask [2], n_mask [2];
    logic [7:0]     r_pend [2], n_pend [2];
    dic_pkg::t_step r_step [2], n_step [2];
    logic           r_fourth [2], n_fourth [2];

    dic_pkg::t_load     load;
    dic_pkg::t_seq_stat stat;
    logic               acc;
    logic               c, t;
    logic [7:0]         bit_sel, sel_mask, sel_pend, t_mask, rep;
    logic [4:0]         sel_base, t_base;
    dic_pkg::t_step     sel_step;

    assign o_in_stall = stat.burst_active || stat.slot_held;
    assign acc        = i_in_valid && !o_in_stall;

    assign c        = i_in_beat.chip_select;
    assign t        = i_in_beat.irq_line[3];
    assign bit_sel  = 8'd1 << i_in_beat.irq_line[2:0];
    assign sel_mask = c ? r_mask[1] : r_mask[0];
    assign sel_pend = c ? r_pend[1] : r_pend[0];
    assign sel_base = c ? r_base[1] : r_base[0];
    assign sel_step = c ? r_step[1] : r_step[0];
    assign t_mask   = t ? r_mask[1] : r_mask[0];
    assign t_base   = t ? r_base[1] : r_base[0];
    assign rep      = sel_mask & ~i_in_beat.data & sel_pend;

    always_comb begin
        n_base   = r_base;
        n_mask   = r_mask;
        n_pend   = r_pend;
        n_step   = r_step;
        n_fourth = r_fourth;
        load     = '0;
        if (acc) begin
            unique case (i_in_beat.kind)
                dic_pkg::KIND_WRITE: begin
                    if (i_in_beat.command_port) begin
                        if (i_in_beat.data[dic_pkg::INIT_BIT]) begin
                            n_fourth[c] = i_in_beat.data[dic_pkg::FOURTH_BIT];
                            n_mask[c]   = dic_pkg::MASK_ALL;
                            n_pend[c]   = 8'd0;
                            n_step[c]   = dic_pkg::STEP_BASE;
                        end
                    end else begin
                        unique case (sel_step)
                            dic_pkg::STEP_BASE: begin
                                n_base[c] = i_in_beat.data[7:3];
                                n_step[c] = dic_pkg::STEP_CASCADE;
                            end
                            dic_pkg::STEP_CASCADE: begin
                                n_step[c] = (c ? r_fourth[1] : r_fourth[0]) ?
                                            dic_pkg::STEP_FOURTH : dic_pkg::STEP_IDLE;
                            end
                            dic_pkg::STEP_FOURTH: begin
                                n_step[c] = dic_pkg::STEP_IDLE;
                            end
                            default: begin
                                n_mask[c] = i_in_beat.data;
                                n_pend[c] = sel_pend & ~rep;
                                if (rep != 8'd0) begin
                                    load.vld   = 1'b1;
                                    load.rkind = dic_pkg::RES_VECTOR;
                                    load.value = {sel_base, dic_pkg::low_index(rep)};
                                    load.rem   = rep & (rep - 8'd1);
                                    load.base  = sel_base;
                                end
                            end
                        endcase
                    end
                end
                dic_pkg::KIND_READ: begin
                    load.vld   = 1'b1;
                    load.rkind = dic_pkg::RES_READ;
                    load.value = i_in_beat.command_port ? sel_pend : sel_mask;
                end
                dic_pkg::KIND_RAISE: begin
                    if ((t_mask & bit_sel) != 8'd0) begin
                        n_pend[t] = (t ? r_pend[1] : r_pend[0]) | bit_sel;
                    end else if (t && r_mask[0][dic_pkg::CASCADE_LINE]) begin
                        n_pend[1] = r_pend[1] | bit_sel;
                    end else begin
                        load.vld   = 1'b1;
                        load.rkind = dic_pkg::RES_VECTOR;
                        load.value = {t_base, i_in_beat.irq_line[2:0]};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_base[i]   <= 5'd0;
                r_mask[i]   <= dic_pkg::MASK_ALL;
                r_pend[i]   <= 8'd0;
                r_step[i]   <= dic_pkg::STEP_IDLE;
                r_fourth[i] <= 1'b0;
            end
        end else begin
            r_base   <= n_base;
            r_mask   <= n_mask;
            r_pend   <= n_pend;
            r_step   <= n_step;
            r_fourth <= n_fourth;
        end
    end

    dic_replay u_replay (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .o_stat      (stat)
    );

endmodule

>>> rtl/core/dic_replay.sv
// Result register and unmask replay sequencer for the interrupt controller.
// Depends on dic_pkg.
module dic_replay (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dic_pkg::t_load    i_load,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output dic_pkg::t_out_beat o_out_beat,
    output dic_pkg::t_seq_stat o_stat
);

    logic               r_vld, n_vld;
    dic_pkg::t_out_beat r_beat, n_beat;
    logic [7:0]         r_rem, n_rem;
    logic [4:0]         r_base, n_base;
    logic               free;
    logic [7:0]         rem_next;

    assign free     = !r_vld || !i_out_stall;
    assign rem_next = r_rem & (r_rem - 8'd1);

    always_comb begin
        n_vld  = r_vld;
        n_beat = r_beat;
        n_rem  = r_rem;
        n_base = r_base;
        if (free) begin
            if (r_rem != 8'd0) begin
                n_vld              = 1'b1;
                n_beat.result_kind = dic_pkg::RES_VECTOR;
                n_beat.value       = {r_base, dic_pkg::low_index(r_rem)};
                n_beat.last        = (rem_next == 8'd0);
                n_rem              = rem_next;
            end else if (i_load.vld) begin
                n_vld              = 1'b1;
                n_beat.result_kind = i_load.rkind;
                n_beat.value       = i_load.value;
                n_beat.last        = (i_load.rem == 8'd0);
                n_rem              = i_load.rem;
                n_base             = i_load.base;
            end else begin
                n_vld = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_rem <= 8'd0;
        end else begin
            r_vld <= n_vld;
            r_rem <= n_rem;
        end
        r_beat <= n_beat;
        r_base <= n_base;
    end

    assign o_out_valid         = r_vld;
    assign o_out_beat          = r_beat;
    assign o_stat.burst_active = (r_rem != 8'd0);
    assign o_stat.slot_held    = r_vld && i_out_stall;

endmodule

>>> rtl/core/dic_checker.sv
// Port-level checks for the dual interrupt controller, bound to the top level.
// Depends on dic_pkg and dual_interrupt_controller_defines.svh.
`include "dual_interrupt_controller_defines.svh"

module dic_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input dic_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dic_pkg::t_out_beat o_out_beat
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `DIC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat))
    `DIC_ASSERT_NEXT(a_read_answers, in_acc && i_in_beat.kind == dic_pkg::KIND_READ, o_out_valid && o_out_beat.result_kind == dic_pkg::RES_READ && o_out_beat.last)
    `DIC_ASSERT_NEXT(a_cmd_silent, in_acc && i_in_beat.kind == dic_pkg::KIND_WRITE && i_in_beat.command_port, !o_out_valid)
    `DIC_ASSERT_NOW(a_burst_blocks, o_out_valid && !o_out_beat.last, o_in_stall)

endmodule

bind dual_interrupt_controller dic_checker u_dic_checker (.*);
